FILE: design/rgb_integrate_fire_spike_encoder_defines.svh
// ----------------------------------------------------------------------------
// RGB integrate-and-fire spike encoder: assertion macros
// Shared wrappers for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef RGB_INTEGRATE_FIRE_SPIKE_ENCODER_DEFINES_SVH
`define RGB_INTEGRATE_FIRE_SPIKE_ENCODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RGBIF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RGBIF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rgbif_pkg.sv
// ----------------------------------------------------------------------------
// RGB integrate-and-fire spike encoder: package
// Field widths, register indexes, item kinds and controller interface types.
// ----------------------------------------------------------------------------
package rgbif_pkg;

	localparam int ACC_W      = 20;
	localparam int PIX_W      = 16;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int THR_W      = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_RESIDUAL  = 8'd1;

	localparam logic [THR_W-1:0] THR_RESET  = 16'd255;
	localparam logic             KEEP_RESET = 1'b1;

	// Item kinds.
	localparam logic KIND_ACCUM = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Channel order in packed words: red is the top lane, blue the bottom.
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [NUM_CH-1:0][ACC_W-1:0] acc_word_t;
	typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic item_load;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic item_query;
		logic out_blocked;
	} ctrl_stat_t;

endpackage

FILE: design/rgb_integrate_fire_spike_encoder.sv
// ----------------------------------------------------------------------------
// RGB integrate-and-fire spike encoder: top level
// Per-pixel red, green and blue accumulators with threshold spike queries.
// ----------------------------------------------------------------------------
// Query path: a query word is accepted, the store is read at the accepting edge
// and the result word is registered at the commit in the execute state.
// Intake: a new word is taken only after the last one commits, as set by the
// single-port accumulator store; a query also waits while the output is held.
// Reset: a clearing pass over every store address zeroes the store, with in_ready
// low; configuration writes are taken throughout.
module rgb_integrate_fire_spike_encoder
	import rgbif_pkg::*;
#(
	parameter int PIXEL_COUNT = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [PIX_W-1:0]      pixel_index,
	input  logic [CH_W-1:0]       red_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       blue_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  spike_red,
	output logic                  spike_green,
	output logic                  spike_blue
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	rgbif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rgbif_dpath #(
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.pixel_index (pixel_index),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.spike_red   (spike_red),
		.spike_green (spike_green),
		.spike_blue  (spike_blue)
	);

endmodule

FILE: design/rgbif_ctrl.sv
// ----------------------------------------------------------------------------
// RGB integrate-and-fire spike encoder: controller
// Sequences the store clearing pass, item intake and read-modify-write commit.
// ----------------------------------------------------------------------------
module rgbif_ctrl
	import rgbif_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// A query waits in the execute state while the output word is still held.
	always_comb begin
		in_ready      = (state_q == S_IDLE);
		cmd.clear_en  = (state_q == S_CLEAR);
		cmd.item_load = in_ready && in_valid;
		cmd.commit    = (state_q == S_EXEC) && !(stat.item_query && stat.out_blocked);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/rgbif_dpath.sv
// ----------------------------------------------------------------------------
// RGB integrate-and-fire spike encoder: datapath
// Accumulator store, item registers, channel update logic, configuration
// registers and the output word register.
// ----------------------------------------------------------------------------
module rgbif_dpath
	import rgbif_pkg::*;
#(
	parameter int PIXEL_COUNT = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output ctrl_stat_t            stat,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  kind,
	input  logic [PIX_W-1:0]      pixel_index,
	input  logic [CH_W-1:0]       red_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       blue_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  spike_red,
	output logic                  spike_green,
	output logic                  spike_blue
);

	localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int IW = (AW > PIX_W) ? AW : PIX_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

	// Accumulator store, no reset: cleared by the sweep after reset.
	acc_word_t mem [PIXEL_COUNT];

	logic [AW-1:0]     clr_addr_q;
	logic [IW-1:0]     idx_wide;
	logic [AW-1:0]     rd_addr;
	logic              rd_in_range;
	acc_word_t         rd_q;
	logic              kind_q;
	logic [PIX_W-1:0]  idx_q;
	logic [AW-1:0]     addr_q;
	logic              in_range_q;
	pix_word_t         pix_q;
	logic [THR_W-1:0]  thr_q;
	logic              keep_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic [NUM_CH-1:0] spike_q;

	logic [NUM_CH-1:0][ACC_W:0]   sum;
	logic [NUM_CH-1:0][ACC_W-1:0] sat;
	logic [NUM_CH-1:0][ACC_W-1:0] fired_val;
	logic [NUM_CH-1:0]            fire;
	logic [NUM_CH-1:0]            spike;
	acc_word_t                    new_word;

	// Address decode of the incoming word.
	always_comb begin
		idx_wide    = IW'(pixel_index);
		rd_addr     = idx_wide[AW-1:0];
		rd_in_range = (32'(pixel_index) < 32'(PIXEL_COUNT));
	end

	// Clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Store read, registered.
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Store write: the clearing sweep or the commit of an in-range item.
	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.commit && in_range_q) begin
			mem[addr_q] <= new_word;
		end
	end

	// Item registers.
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q     <= kind;
			idx_q      <= pixel_index;
			addr_q     <= rd_addr;
			in_range_q <= rd_in_range;
			pix_q      <= {red_in, green_in, blue_in};
		end
	end

	// Per-channel saturating add for accumulate, threshold test and
	// residual or clear for query.
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum[ch]       = {1'b0, rd_q[ch]} + (ACC_W + 1)'(pix_q[ch]);
			sat[ch]       = sum[ch][ACC_W] ? ACC_MAX : sum[ch][ACC_W-1:0];
			fire[ch]      = (rd_q[ch] > ACC_W'(thr_q));
			fired_val[ch] = keep_q ? (rd_q[ch] - ACC_W'(thr_q)) : '0;
			if (kind_q == KIND_QUERY) begin
				new_word[ch] = fire[ch] ? fired_val[ch] : rd_q[ch];
			end else begin
				new_word[ch] = sat[ch];
			end
			spike[ch] = (kind_q == KIND_QUERY) && in_range_q && fire[ch];
		end
	end

	// Configuration registers; a zero threshold write is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			keep_q <= KEEP_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FIRE_THRESHOLD && cfg_data != '0) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
			if (cfg_index == REG_KEEP_RESIDUAL) begin
				keep_q <= cfg_data[0];
			end
		end
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && kind_q == KIND_QUERY) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (cmd.commit && kind_q == KIND_QUERY) begin
			pixel_out_q <= idx_q;
			spike_q     <= spike;
		end
	end

	always_comb begin
		stat.clear_last  = (clr_addr_q == LAST_ADDR);
		stat.item_query  = (kind_q == KIND_QUERY);
		stat.out_blocked = out_valid_q && !out_ready;
		out_valid        = out_valid_q;
		pixel_out        = pixel_out_q;
		spike_red        = spike_q[CH_RED];
		spike_green      = spike_q[CH_GREEN];
		spike_blue       = spike_q[CH_BLUE];
	end

endmodule

FILE: design/rgbif_checker.sv
// ----------------------------------------------------------------------------
// RGB integrate-and-fire spike encoder: port checker
// Watches the top-level ports for intake pacing and output word ordering.
// ----------------------------------------------------------------------------
`include "rgb_integrate_fire_spike_encoder_defines.svh"

module rgbif_checker
	import rgbif_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             kind,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] pixel_out,
	input logic             spike_red,
	input logic             spike_green,
	input logic             spike_blue
);

	// A held output word keeps its payload.
	`RGBIF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable({spike_red, spike_green, spike_blue}), "output word changed while stalled")

	// The store is busy in the cycle after every accepted word.
	`RGBIF_ASSERT_NEXT(a_intake_gap, in_valid && in_ready, !in_ready, "word accepted on consecutive cycles")

	// A new result only appears from the execute cycle, never from idle.
	`RGBIF_ASSERT_SAME(a_out_from_exec, $rose(out_valid), $past(!in_ready), "result appeared without an item in flight")

	// An accumulate word never produces a result on an empty output.
	`RGBIF_ASSERT_SAME(a_accum_silent, $past(in_valid && in_ready && kind == KIND_ACCUM, 2) && !$past(out_valid), !out_valid, "accumulate word produced a result")

endmodule

bind rgb_integrate_fire_spike_encoder rgbif_checker u_rgbif_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_out   (pixel_out),
	.spike_red   (spike_red),
	.spike_green (spike_green),
	.spike_blue  (spike_blue)
);
